>>> hdl/piezo_envelope_trigger_assert.svh
// Assertion macros shared by the piezo envelope trigger modules.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef PIEZO_ENVELOPE_TRIGGER_ASSERT_SVH
`define PIEZO_ENVELOPE_TRIGGER_ASSERT_SVH

// Same-cycle implication
`define PET_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PET_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/pet_pkg.sv
package pet_pkg;

    // Fixed formats
    localparam int SAMPLE_BITS = 10;
    localparam int FRAC_BITS   = 16;
    localparam int LEVEL_W     = FRAC_BITS + 1;
    localparam int COEF_W      = 16;
    localparam int PROD_W      = 2 * LEVEL_W;
    localparam int CNT_W       = $clog2(FRAC_BITS);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_W       = 17;
    localparam int IN_W        = 16;
    localparam int OUT_W       = 40;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [LEVEL_W-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THR_LOW  = 3'd0,
        CFG_THR_HIGH = 3'd1,
        CFG_ATTACK   = 3'd2,
        CFG_RELEASE  = 3'd3,
        CFG_TRIGGER  = 3'd4,
        CFG_RETRIG   = 3'd5
    } t_cfg_idx;

    // What a request asks of the back end
    typedef enum logic [1:0] {
        K_HOLD,
        K_ZERO,
        K_ONE,
        K_DIV
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [SAMPLE_BITS-1:0] num;
        logic [SAMPLE_BITS-1:0] den;
    } t_job;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] thr_low;
        logic [SAMPLE_BITS-1:0] thr_high;
    } t_map_cfg;

    typedef struct packed {
        logic [COEF_W-1:0]  atk_coef;
        logic [COEF_W-1:0]  rel_coef;
        logic [LEVEL_W-1:0] trig_lvl;
        logic [LEVEL_W-1:0] retrig_lvl;
    } t_env_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL1,
        S_MUL2,
        S_OUT
    } t_state;

endpackage

>>> hdl/pet_front.sv
module pet_front
    import pet_pkg::*;
(
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [SAMPLE_BITS-1:0] i_raw_sample,
    input  logic                   i_sample_valid,
    input  t_map_cfg               i_cfg,
    input  logic                   i_q_full,
    output logic                   o_q_push,
    output t_job                   o_q_job
);

    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;

    assign lo = i_cfg.thr_low;
    assign hi = i_cfg.thr_high;

    // Handshake: take a request whenever the queue has room
    assign o_s_axis_tready = !i_q_full;
    assign o_q_push        = i_s_axis_tvalid && !i_q_full;

    // Classify the sample against the mapping window
    always_comb begin
        o_q_job.kind = K_HOLD;
        o_q_job.num  = '0;
        o_q_job.den  = '0;
        if (i_sample_valid) begin
            if (lo == hi) begin
                o_q_job.kind = K_ZERO;
            end else if (lo < hi) begin
                if (i_raw_sample <= lo) begin
                    o_q_job.kind = K_ZERO;
                end else if (i_raw_sample >= hi) begin
                    o_q_job.kind = K_ONE;
                end else begin
                    o_q_job.kind = K_DIV;
                    o_q_job.num  = i_raw_sample - lo;
                    o_q_job.den  = hi - lo;
                end
            end else begin
                // inverted window
                if (i_raw_sample >= lo) begin
                    o_q_job.kind = K_ZERO;
                end else if (i_raw_sample <= hi) begin
                    o_q_job.kind = K_ONE;
                end else begin
                    o_q_job.kind = K_DIV;
                    o_q_job.num  = lo - i_raw_sample;
                    o_q_job.den  = lo - hi;
                end
            end
        end
    end

endmodule

>>> hdl/pet_queue.sv
`include "piezo_envelope_trigger_assert.svh"

module pet_queue
    import pet_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_head
);

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    `PET_CHECK(a_no_overflow, i_push, !o_full || i_pop, "push into full queue")
    `PET_CHECK(a_no_underflow, i_pop, !o_empty, "pop from empty queue")

endmodule

>>> hdl/pet_back.sv
`include "piezo_envelope_trigger_assert.svh"

module pet_back
    import pet_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_env_cfg         i_cfg,
    input  logic             i_q_empty,
    input  t_job             i_q_head,
    output logic             o_q_pop,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata
);

    t_state                 r_state, n_state;
    logic [LEVEL_W-1:0]     r_level, n_level;
    logic [LEVEL_W-1:0]     r_env, n_env;
    logic                   r_gate, n_gate;
    logic                   r_trig, n_trig;
    logic [SAMPLE_BITS-1:0] r_rem, n_rem;
    logic [SAMPLE_BITS-1:0] r_den, n_den;
    logic [FRAC_BITS-1:0]   r_quo, n_quo;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [PROD_W-1:0]      r_prod, n_prod;
    logic [LEVEL_W-1:0]     r_cmp, n_cmp;
    logic                   r_out_valid, n_out_valid;
    logic [OUT_W-1:0]       r_out_data, n_out_data;

    logic [SAMPLE_BITS:0]   rem2;
    logic                   ge;
    logic [COEF_W-1:0]      coef;
    logic [LEVEL_W+COEF_W-1:0] mul_a;
    logic [PROD_W-1:0]      mul_b;
    logic [PROD_W-1:0]      env_sum;
    logic                   out_free;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // Datapath pieces
    assign rem2    = {r_rem, 1'b0};
    assign ge      = (rem2 >= {1'b0, r_den});
    assign coef    = (r_level > r_env) ? i_cfg.atk_coef : i_cfg.rel_coef;
    assign mul_a   = r_env * coef;
    assign mul_b   = r_cmp * r_level;
    assign env_sum = r_prod + mul_b;

    // State register and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= '0;
            r_env       <= '0;
            r_gate      <= 1'b0;
            r_trig      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_env       <= n_env;
            r_gate      <= n_gate;
            r_trig      <= n_trig;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_den      <= n_den;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_prod     <= n_prod;
        r_cmp      <= n_cmp;
        r_out_data <= n_out_data;
    end

    // Sequencer: map, divide if the job asks for it, two multiply steps, then hand off
    always_comb begin
        n_state     = r_state;
        n_level     = r_level;
        n_env       = r_env;
        n_gate      = r_gate;
        n_trig      = r_trig;
        n_rem       = r_rem;
        n_den       = r_den;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_prod      = r_prod;
        n_cmp       = r_cmp;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        o_q_pop     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = S_MUL1;
                    case (i_q_head.kind)
                        K_ZERO: n_level = '0;
                        K_ONE:  n_level = ONE_Q;
                        K_DIV: begin
                            n_rem   = i_q_head.num;
                            n_den   = i_q_head.den;
                            n_cnt   = '0;
                            n_state = S_DIV;
                        end
                        default: n_level = r_level;
                    endcase
                end
            end
            S_DIV: begin
                // restoring division, one quotient bit per cycle
                n_rem = ge ? SAMPLE_BITS'(rem2 - {1'b0, r_den}) : rem2[SAMPLE_BITS-1:0];
                n_quo = {r_quo[FRAC_BITS-2:0], ge};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(FRAC_BITS - 1)) begin
                    n_level = {1'b0, n_quo};
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                n_prod  = PROD_W'(mul_a);
                n_cmp   = ONE_Q - LEVEL_W'(coef);
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_env  = env_sum[FRAC_BITS +: LEVEL_W];
                n_trig = 1'b0;
                if (r_gate) begin
                    if (r_level <= i_cfg.retrig_lvl) begin
                        n_gate = 1'b0;
                    end
                end else if (r_level > i_cfg.trig_lvl) begin
                    n_gate = 1'b1;
                    n_trig = 1'b1;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_data  = {{(OUT_W - 2 * LEVEL_W - 2){1'b0}},
                                   r_trig, r_gate, r_env, r_level};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `PET_CHECK(a_pop_idle, o_q_pop, (r_state == S_IDLE) && !i_q_empty, "pop outside idle")
    `PET_CHECK(a_trig_closed, (r_state == S_MUL2) && n_trig, !r_gate, "trigger with gate open")
    `PET_CHECK_NEXT(a_env_range, r_state == S_MUL2, r_env <= ONE_Q, "envelope above one")
    `PET_CHECK_NEXT(a_div_end, (r_state == S_DIV) && (r_cnt == CNT_W'(FRAC_BITS - 1)),
                    r_state == S_MUL1, "divider did not finish")

endmodule

>>> hdl/piezo_envelope_trigger.sv
// Piezo envelope follower with hysteresis trigger, one channel.
// Input stream: one request per frame tick. tuser carries sample_valid,
// tdata[9:0] the raw converter reading (used only when sample_valid is set).
// Output stream: one result per request, tdata from bit 0 up holds
// level_out (17), envelope_out (17), gate_out (1), trigger_pulse (1).
// Config channel: i_cfg_index selects the register, always ready; write only
// while no request is in flight. Unknown indexes are ignored.
// A request whose sample lands inside the window passes the queue pop, the
// 16-step restoring divider, two multiply steps and the output load; other
// requests skip the divider. The back end takes the next request only once
// the last one has been handed to the output register.
// A two-entry queue lets the input side keep accepting while the back end
// computes; a full queue drops s_axis_tready.
// When the receiver stalls, the result sits in the output register and the
// back end waits after finishing the next request; the queue then fills.
// Synchronous active-low reset clears level, envelope and gate, empties the
// queue and reloads the register defaults.
module piezo_envelope_trigger
    import pet_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [IN_W-1:0]      i_s_axis_tdata,  // [9:0] raw_sample, rest zero
    input  logic                 i_s_axis_tuser,  // [0] sample_valid
    // master stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [OUT_W-1:0]     o_m_axis_tdata,  // level, envelope, gate, trigger
    // config writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [SAMPLE_BITS-1:0] r_thr_low;
    logic [SAMPLE_BITS-1:0] r_thr_high;
    logic [COEF_W-1:0]      r_atk;
    logic [COEF_W-1:0]      r_rel;
    logic [LEVEL_W-1:0]     r_trig_lvl;
    logic [LEVEL_W-1:0]     r_retrig_lvl;

    t_map_cfg map_cfg;
    t_env_cfg env_cfg;
    logic     q_push;
    t_job     q_push_job;
    logic     q_full;
    logic     q_pop;
    logic     q_empty;
    t_job     q_head;

    assign o_cfg_ready = 1'b1;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_low    <= SAMPLE_BITS'(0);
            r_thr_high   <= SAMPLE_BITS'(1023);
            r_atk        <= COEF_W'(6554);
            r_rel        <= COEF_W'(45875);
            r_trig_lvl   <= LEVEL_W'(13107);
            r_retrig_lvl <= LEVEL_W'(6554);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_THR_LOW:  r_thr_low    <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_THR_HIGH: r_thr_high   <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_ATTACK:   r_atk        <= i_cfg_data[COEF_W-1:0];
                CFG_RELEASE:  r_rel        <= i_cfg_data[COEF_W-1:0];
                CFG_TRIGGER:  r_trig_lvl   <= i_cfg_data[LEVEL_W-1:0];
                CFG_RETRIG:   r_retrig_lvl <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    assign map_cfg.thr_low     = r_thr_low;
    assign map_cfg.thr_high    = r_thr_high;
    assign env_cfg.atk_coef    = r_atk;
    assign env_cfg.rel_coef    = r_rel;
    assign env_cfg.trig_lvl    = r_trig_lvl;
    assign env_cfg.retrig_lvl  = r_retrig_lvl;

    pet_front u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_raw_sample    (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_sample_valid  (i_s_axis_tuser),
        .i_cfg           (map_cfg),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_job         (q_push_job)
    );

    pet_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_job (q_push_job),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_empty    (q_empty),
        .o_head     (q_head)
    );

    pet_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (env_cfg),
        .i_q_empty       (q_empty),
        .i_q_head        (q_head),
        .o_q_pop         (q_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

>>> test/pet_tick_checker.sv
module pet_tick_checker
    import pet_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream as seen on the wire
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [IN_W-1:0]      i_in_data,
    input  logic                 i_in_user,
    // result stream as seen on the wire
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [OUT_W-1:0]     i_out_data,
    // register writes
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // status for the top
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_result_count,
    output int                   o_pulse_count
);

    // Register values after reset
    localparam logic [SAMPLE_BITS-1:0] RST_THR_LOW  = '0;
    localparam logic [SAMPLE_BITS-1:0] RST_THR_HIGH = 10'd1023;
    localparam logic [COEF_W-1:0]      RST_ATTACK   = 16'd6554;
    localparam logic [COEF_W-1:0]      RST_RELEASE  = 16'd45875;
    localparam logic [LEVEL_W-1:0]     RST_TRIGGER  = 17'd13107;
    localparam logic [LEVEL_W-1:0]     RST_RETRIG   = 17'd6554;

    // Result word layout, lowest bit first
    localparam int ENV_LSB   = LEVEL_W;
    localparam int GATE_BIT  = 2 * LEVEL_W;
    localparam int PULSE_BIT = 2 * LEVEL_W + 1;
    localparam int PAD_LSB   = 2 * LEVEL_W + 2;

    // Keeps the log readable when the block is badly broken
    localparam int REPORT_CAP = 40;

    typedef struct {
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] envelope;
        logic               gate;
        logic               pulse;
    } t_tick_result;

    t_map_cfg           map_cfg;
    t_env_cfg           env_cfg;
    logic [LEVEL_W-1:0] level_now;
    logic [LEVEL_W-1:0] env_now;
    logic               gate_now;
    t_tick_result       tick_results_q[$];
    int                 fails   = 0;
    int                 results = 0;
    int                 pulses  = 0;

    // Linear map of a raw reading onto [0, ONE]; reversed window when low > high
    function automatic logic [LEVEL_W-1:0] scale_sample(t_map_cfg m,
                                                        logic [SAMPLE_BITS-1:0] raw);
        logic [31:0] num;
        logic [31:0] den;
        if (m.thr_low == m.thr_high)
            return '0;
        if (m.thr_low < m.thr_high) begin
            if (raw <= m.thr_low) return '0;
            if (raw >= m.thr_high) return ONE_Q;
            num = 32'(raw) - 32'(m.thr_low);
            den = 32'(m.thr_high) - 32'(m.thr_low);
        end else begin
            if (raw >= m.thr_low) return '0;
            if (raw <= m.thr_high) return ONE_Q;
            num = 32'(m.thr_low) - 32'(raw);
            den = 32'(m.thr_low) - 32'(m.thr_high);
        end
        return LEVEL_W'((num << FRAC_BITS) / den);
    endfunction

    // One-pole step, truncated. A 16-bit coefficient never reaches ONE.
    function automatic logic [LEVEL_W-1:0] follow(logic [LEVEL_W-1:0] env,
                                                  logic [LEVEL_W-1:0] lvl,
                                                  logic [COEF_W-1:0] coef);
        logic [63:0] acc;
        acc = 64'(env) * 64'(coef) + (64'(ONE_Q) - 64'(coef)) * 64'(lvl);
        return acc[FRAC_BITS +: LEVEL_W];
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            fails++;
            if (fails <= REPORT_CAP)
                $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : track
        t_tick_result fresh;
        t_tick_result due;
        if (!i_rst_n) begin
            map_cfg.thr_low     = RST_THR_LOW;
            map_cfg.thr_high    = RST_THR_HIGH;
            env_cfg.atk_coef    = RST_ATTACK;
            env_cfg.rel_coef    = RST_RELEASE;
            env_cfg.trig_lvl    = RST_TRIGGER;
            env_cfg.retrig_lvl  = RST_RETRIG;
            level_now           = '0;
            env_now             = '0;
            gate_now            = 1'b0;
            tick_results_q.delete();
        end else begin
            // register write; unknown indexes change nothing
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_THR_LOW:  map_cfg.thr_low    = i_cfg_data[SAMPLE_BITS-1:0];
                    CFG_THR_HIGH: map_cfg.thr_high   = i_cfg_data[SAMPLE_BITS-1:0];
                    CFG_ATTACK:   env_cfg.atk_coef   = i_cfg_data[COEF_W-1:0];
                    CFG_RELEASE:  env_cfg.rel_coef   = i_cfg_data[COEF_W-1:0];
                    CFG_TRIGGER:  env_cfg.trig_lvl   = i_cfg_data[LEVEL_W-1:0];
                    CFG_RETRIG:   env_cfg.retrig_lvl = i_cfg_data[LEVEL_W-1:0];
                    default: ;
                endcase
            end

            // one tick: map, smooth, then the gate on the level itself
            if (i_in_valid && i_in_ready) begin
                if (i_in_user)
                    level_now = scale_sample(map_cfg, i_in_data[SAMPLE_BITS-1:0]);
                env_now = follow(env_now, level_now,
                                 (level_now > env_now) ? env_cfg.atk_coef : env_cfg.rel_coef);
                fresh.pulse = 1'b0;
                if (gate_now) begin
                    if (level_now <= env_cfg.retrig_lvl)
                        gate_now = 1'b0;
                end else if (level_now > env_cfg.trig_lvl) begin
                    gate_now    = 1'b1;
                    fresh.pulse = 1'b1;
                end
                fresh.level    = level_now;
                fresh.envelope = env_now;
                fresh.gate     = gate_now;
                tick_results_q.push_back(fresh);
            end

            // compare against the oldest outstanding tick
            if (i_out_valid && i_out_ready) begin
                results++;
                if (i_out_data[PULSE_BIT])
                    pulses++;
                if (tick_results_q.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_CAP)
                        $error("result with no tick outstanding: tdata %h", i_out_data);
                end else begin
                    due = tick_results_q.pop_front();
                    check_field("level_out", due.level, i_out_data[LEVEL_W-1:0]);
                    check_field("envelope_out", due.envelope, i_out_data[ENV_LSB +: LEVEL_W]);
                    check_field("gate_out", due.gate, i_out_data[GATE_BIT]);
                    check_field("trigger_pulse", due.pulse, i_out_data[PULSE_BIT]);
                    check_field("tdata padding", 0, i_out_data[OUT_W-1:PAD_LSB]);
                end
            end
        end
        o_pending      <= tick_results_q.size();
        o_fail_count   <= fails;
        o_result_count <= results;
        o_pulse_count  <= pulses;
    end

endmodule

>>> test/tb.sv
module tb;
    import pet_pkg::*;

    // Indexes that map to no register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    localparam int RANDOM_TICKS = 750;
    localparam int CALM_FROM    = 650;
    localparam int SETTLE       = 40;
    localparam int MAX_RAW      = (1 << SAMPLE_BITS) - 1;
    localparam int ONE_INT      = 1 << FRAC_BITS;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [IN_W-1:0]      i_s_axis_tdata  = '0;
    logic                 i_s_axis_tuser  = 1'b0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b1;
    logic [OUT_W-1:0]     o_m_axis_tdata;
    logic                 i_cfg_valid     = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [CFG_W-1:0]     i_cfg_data      = '0;

    int fail_count;
    int pending;
    int result_count;
    int pulse_count;

    int   ticks_sent   = 0;
    int   samples_sent = 0;
    int   random_ticks = 0;
    int   settings     = 1;
    int   stall_left   = 0;
    logic calm         = 1'b0;
    logic quiet        = 1'b0;

    piezo_envelope_trigger uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    pet_tick_checker tick_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_s_axis_tvalid),
        .i_in_ready     (o_s_axis_tready),
        .i_in_data      (i_s_axis_tdata),
        .i_in_user      (i_s_axis_tuser),
        .i_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .i_out_data     (o_m_axis_tdata),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_pulse_count  (pulse_count)
    );

    // 20-unit clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Result side back-pressure in bursts of random length
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left      <= stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (!calm && !quiet && $urandom_range(0, 7) == 0) begin
            stall_left      <= $urandom_range(0, 12);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Valid is left high between back-to-back writes; the caller drops it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic end_writes();
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        settings++;
    endtask

    // One frame tick; afterwards the sender may go quiet for a burst
    task automatic send_tick(input logic has_sample, input logic [SAMPLE_BITS-1:0] raw);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= has_sample;
        i_s_axis_tdata  <= IN_W'(raw);
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        ticks_sent++;
        if (has_sample)
            samples_sent++;
        if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    // Hold off until every tick has come back, then let the pipe settle
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Random register set, extremes weighted in, spare bits above each width set at random
    task automatic random_setup();
        int               lo;
        int               hi;
        int               trig;
        int               retrig;
        logic [CFG_W-1:0] word;
        case ($urandom_range(0, 9))
            0: begin lo = 0; hi = MAX_RAW; end
            1: begin lo = MAX_RAW; hi = 0; end
            2: begin lo = $urandom_range(0, MAX_RAW); hi = lo; end
            3, 4: begin
                hi = $urandom_range(0, 900);
                lo = $urandom_range(hi + 1, MAX_RAW);
            end
            default: begin
                lo = $urandom_range(0, 900);
                hi = $urandom_range(lo + 1, MAX_RAW);
            end
        endcase
        case ($urandom_range(0, 7))
            0: trig = ONE_INT;
            1: trig = $urandom_range(0, (1 << CFG_W) - 1);
            2: trig = 0;
            default: trig = $urandom_range(1000, 50000);
        endcase
        case ($urandom_range(0, 5))
            0: retrig = 0;
            1: retrig = trig;
            default: retrig = $urandom_range(0, (trig > ONE_INT) ? ONE_INT : trig);
        endcase

        word = CFG_W'($urandom());
        word[SAMPLE_BITS-1:0] = SAMPLE_BITS'(lo);
        write_reg(CFG_THR_LOW, word);
        word = CFG_W'($urandom());
        word[SAMPLE_BITS-1:0] = SAMPLE_BITS'(hi);
        write_reg(CFG_THR_HIGH, word);
        word = CFG_W'($urandom());
        case ($urandom_range(0, 4))
            0: word[COEF_W-1:0] = '0;
            1: word[COEF_W-1:0] = '1;
            default: ;
        endcase
        write_reg(CFG_ATTACK, word);
        word = CFG_W'($urandom());
        case ($urandom_range(0, 4))
            0: word[COEF_W-1:0] = '0;
            1: word[COEF_W-1:0] = '1;
            default: ;
        endcase
        write_reg(CFG_RELEASE, word);
        write_reg(CFG_TRIGGER, CFG_W'(trig));
        write_reg(CFG_RETRIG, CFG_W'(retrig));
        if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, CFG_W'($urandom()));
        end_writes();
    endtask

    // A hit: a short rise to a peak, then a decay of held or falling samples
    task automatic strike();
        int base;
        int peak;
        int steps;
        int k;
        base  = $urandom_range(0, 200);
        peak  = $urandom_range(base, MAX_RAW);
        steps = $urandom_range(1, 3);
        for (k = 1; k <= steps; k++)
            send_tick(1'b1, SAMPLE_BITS'(base + (peak - base) * k / steps));
        steps = $urandom_range(2, 10);
        for (k = 0; k < steps; k++) begin
            if ($urandom_range(0, 2) == 0) begin
                send_tick(1'b0, SAMPLE_BITS'($urandom_range(0, MAX_RAW)));
            end else begin
                peak = base + (peak - base) / 2;
                send_tick(1'b1, SAMPLE_BITS'(peak));
            end
        end
    endtask

    task automatic noise_tick();
        case ($urandom_range(0, 5))
            0: send_tick(1'b1, '0);
            1: send_tick(1'b1, '1);
            2: send_tick(1'b0, SAMPLE_BITS'($urandom()));
            default: send_tick(1'b1, SAMPLE_BITS'($urandom()));
        endcase
    endtask

    initial begin : stimulus
        int ticks_at_start;
        int phase_end;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: end points, held level, a one-step ramp
        send_tick(1'b1, '0);
        send_tick(1'b1, '1);
        send_tick(1'b0, '1);
        send_tick(1'b0, '0);
        send_tick(1'b0, '1);
        send_tick(1'b1, '0);
        send_tick(1'b1, '0);
        send_tick(1'b1, 10'd1);
        send_tick(1'b1, 10'd1022);
        send_tick(1'b1, 10'd512);
        send_tick(1'b1, 10'd100);
        drain();

        // Reversed window, spare bits set, coefficient extremes,
        // trigger out of reach, writes to unused indexes
        write_reg(CFG_THR_LOW, '1);
        write_reg(CFG_THR_HIGH, 17'h1FC00);
        write_reg(CFG_ATTACK, '1);
        write_reg(CFG_RELEASE, 17'h10000);
        write_reg(CFG_TRIGGER, '1);
        write_reg(CFG_RETRIG, '1);
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, 17'h0ABCD);
        end_writes();
        send_tick(1'b1, '1);
        send_tick(1'b1, '0);
        send_tick(1'b1, 10'd500);
        send_tick(1'b1, '1);
        send_tick(1'b1, '0);
        drain();

        // Equal thresholds give level zero everywhere
        write_reg(CFG_THR_LOW, 17'd300);
        write_reg(CFG_THR_HIGH, 17'd300);
        end_writes();
        send_tick(1'b1, 10'd300);
        send_tick(1'b1, '0);
        send_tick(1'b1, '1);
        drain();

        // Trigger exactly at full scale: a full-scale level still does not open
        write_reg(CFG_THR_LOW, '0);
        write_reg(CFG_THR_HIGH, 17'd1);
        write_reg(CFG_ATTACK, '0);
        write_reg(CFG_TRIGGER, 17'(ONE_INT));
        write_reg(CFG_RETRIG, '0);
        end_writes();
        send_tick(1'b1, '1);
        send_tick(1'b1, '0);
        send_tick(1'b1, 10'd1);
        send_tick(1'b0, '0);
        drain();

        // Random phases of hits and noise under random settings
        while (random_ticks < RANDOM_TICKS) begin
            random_setup();
            quiet     = ($urandom_range(0, 3) == 0);
            phase_end = random_ticks + $urandom_range(60, 120);
            while (random_ticks < phase_end && random_ticks < RANDOM_TICKS) begin
                if (random_ticks >= CALM_FROM)
                    calm = 1'b1;
                ticks_at_start = ticks_sent;
                if ($urandom_range(0, 3) == 0)
                    noise_tick();
                else
                    strike();
                random_ticks += ticks_sent - ticks_at_start;
            end
            drain();
        end

        $display("Ran %0d ticks (%0d with a new sample) under %0d register settings;",
                 ticks_sent, samples_sent, settings);
        $display("checked %0d results, %0d of them with a trigger pulse.",
                 result_count, pulse_count);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
